// File: design/cfl_pkg.sv
// Shared constants and types for the CFL time step reduction block.
`timescale 1ns / 1ps
`default_nettype none
package cfl_pkg;
  localparam int TimeW = 48;
  localparam int CoefW = 16;
  localparam int RadW = 32;
  localparam int VelW = 32;
  localparam int SndW = 31;
  localparam int SigW = 51;
  localparam int NumW = 48;
  localparam int QueueDepth = 4;

  localparam logic [TimeW-1:0] TimeMax = {TimeW{1'b1}};
  localparam logic [TimeW-1:0] MaxStepReset = {TimeW{1'b1}};
  localparam logic [CoefW-1:0] CourantReset = 16'd2048;
  localparam logic [CoefW-1:0] ViscReset = 16'd4096;
  localparam logic [CoefW-1:0] GrowthReset = 16'd4506;

  localparam logic [2:0] RegMaxStep = 3'd0;
  localparam logic [2:0] RegCourant = 3'd1;
  localparam logic [2:0] RegVisc = 3'd2;
  localparam logic [2:0] RegGrowth = 3'd3;
  localparam logic [2:0] RegPrevStep = 3'd4;

  // Zone classified by the front end, handed to the divider back end.
  typedef struct packed {
    logic            no_limit;
    logic            zero_limit;
    logic [NumW-1:0] num;
    logic [SigW-1:0] sig;
    logic            last;
  } zone_t;
endpackage
`default_nettype wire

// File: design/cfl_front.sv
// Front end: compression, signal speed and numerator for one zone.
`timescale 1ns / 1ps
`default_nettype none
module cfl_front (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic [cfl_pkg::RadW-1:0] inner_radius,
  input  wire logic [cfl_pkg::RadW-1:0] outer_radius,
  input  wire logic signed [cfl_pkg::VelW-1:0] inner_velocity,
  input  wire logic signed [cfl_pkg::VelW-1:0] outer_velocity,
  input  wire logic [cfl_pkg::SndW-1:0] sound_speed,
  input  wire logic                    last_zone,
  input  wire logic [cfl_pkg::CoefW-1:0] courant_factor,
  input  wire logic [cfl_pkg::CoefW-1:0] quad_viscosity,
  output logic                         q_valid,
  input  wire logic                    q_ready,
  output cfl_pkg::zone_t               q_data
);
  logic signed [cfl_pkg::VelW:0] drop;
  logic [cfl_pkg::VelW-1:0] comp;
  logic [cfl_pkg::RadW-1:0] width;
  logic [cfl_pkg::SigW-1:0] visc_term;
  logic [cfl_pkg::SigW-1:0] sig;
  logic [cfl_pkg::NumW-1:0] num;

  assign in_ready = !q_valid || q_ready;

  // Positive part of the velocity drop across the zone
  assign drop = {inner_velocity[cfl_pkg::VelW-1], inner_velocity}
              - {outer_velocity[cfl_pkg::VelW-1], outer_velocity};
  assign comp = drop[cfl_pkg::VelW] ? '0 : drop[cfl_pkg::VelW-1:0];
  assign visc_term = cfl_pkg::SigW'({quad_viscosity, 2'b00}) * cfl_pkg::SigW'(comp);
  assign sig = cfl_pkg::SigW'({sound_speed, 12'd0}) + visc_term;
  assign width = outer_radius - inner_radius;
  assign num = cfl_pkg::NumW'(courant_factor) * cfl_pkg::NumW'(width);

  // Output register toward the queue
  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (in_ready) begin
      q_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      q_data.no_limit <= (sig == '0);
      q_data.zero_limit <= (outer_radius < inner_radius);
      q_data.num <= num;
      q_data.sig <= sig;
      q_data.last <= last_zone;
    end
  end
endmodule
`default_nettype wire

// File: design/cfl_queue.sv
// Short FIFO between front end and back end.
`timescale 1ns / 1ps
`default_nettype none
module cfl_queue #(
  parameter int Depth = cfl_pkg::QueueDepth
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           wr_valid,
  output logic                wr_ready,
  input  wire cfl_pkg::zone_t wr_data,
  output logic                rd_valid,
  input  wire logic           rd_ready,
  output cfl_pkg::zone_t      rd_data
);
  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
  cfl_pkg::zone_t mem [Depth];
  logic [AW-1:0] wp, rp;
  logic [AW:0] count;
  logic push, pop;

  assign wr_ready = (count != (AW+1)'(Depth));
  assign rd_valid = (count != '0);
  assign rd_data = mem[rp];
  assign push = wr_valid && wr_ready;
  assign pop = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      count <= '0;
    end else begin
      if (push) wp <= (wp == AW'(Depth-1)) ? '0 : wp + 1'b1;
      if (pop) rp <= (rp == AW'(Depth-1)) ? '0 : rp + 1'b1;
      count <= count + (AW+1)'(push) - (AW+1)'(pop);
    end
    if (push) mem[wp] <= wr_data;
  end
endmodule
`default_nettype wire

// File: design/cfl_back.sv
// Back end: bit-serial divider, running minimum, growth cap and result register.
`timescale 1ns / 1ps
`default_nettype none
module cfl_back (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       q_valid,
  output logic                            q_ready,
  input  wire cfl_pkg::zone_t             q_data,
  input  wire logic [cfl_pkg::TimeW-1:0]  max_step,
  input  wire logic [cfl_pkg::CoefW-1:0]  growth_limit,
  input  wire logic [cfl_pkg::TimeW-1:0]  previous_step,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [cfl_pkg::TimeW-1:0]       time_step
);
  // Quotient bits: 48-bit numerator shifted by 32 gives 80 bits; 49 needed for saturation
  localparam int QW = 80;
  localparam int RW = cfl_pkg::SigW + 1;

  typedef enum logic [1:0] {S_IDLE, S_DIV, S_CAP, S_OUT} state_t;
  state_t state;
  logic [6:0] bit_cnt;
  logic [QW-1:0] dividend;
  logic [RW-1:0] rem;
  logic [cfl_pkg::SigW-1:0] den;
  logic [cfl_pkg::TimeW:0] quo;
  logic sat;
  logic last;
  logic open;
  logic [cfl_pkg::TimeW-1:0] running_minimum;
  logic [cfl_pkg::TimeW-1:0] cur;
  logic [cfl_pkg::TimeW+cfl_pkg::CoefW-1:0] cap_prod;
  logic [cfl_pkg::TimeW-1:0] cap;
  logic [RW-1:0] rem_sh;
  logic [RW-1:0] rem_next;
  logic q_bit;
  logic [cfl_pkg::TimeW-1:0] lim;

  assign q_ready = (state == S_IDLE);
  assign cur = open ? running_minimum : max_step;

  // One restoring step per cycle
  assign rem_sh = {rem[RW-2:0], dividend[QW-1]};
  assign q_bit = (rem_sh >= {1'b0, den});
  assign rem_next = q_bit ? rem_sh - {1'b0, den} : rem_sh;
  assign lim = (sat || quo[cfl_pkg::TimeW]) ? cfl_pkg::TimeMax : quo[cfl_pkg::TimeW-1:0];

  assign cap_prod = previous_step * growth_limit;
  assign cap = (cap_prod[cfl_pkg::TimeW+cfl_pkg::CoefW-1:cfl_pkg::TimeW+12] != '0)
             ? cfl_pkg::TimeMax : cap_prod[cfl_pkg::TimeW+11:12];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      open <= 1'b0;
      running_minimum <= cfl_pkg::MaxStepReset;
    end else begin
      // Result register: set when a step is issued, cleared once taken
      if (state == S_OUT) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (q_valid && q_ready) begin
            last <= q_data.last;
            if (q_data.no_limit) begin
              running_minimum <= cur;
              state <= q_data.last ? S_CAP : S_IDLE;
              open <= 1'b1;
            end else if (q_data.zero_limit) begin
              running_minimum <= '0;
              open <= 1'b1;
              state <= q_data.last ? S_CAP : S_IDLE;
            end else begin
              dividend <= {q_data.num, 32'd0};
              den <= q_data.sig;
              rem <= '0;
              quo <= '0;
              sat <= 1'b0;
              bit_cnt <= 7'(QW);
              state <= S_DIV;
            end
          end
        end
        S_DIV: begin
          if (bit_cnt == '0) begin
            if (lim < cur) running_minimum <= lim;
            else running_minimum <= cur;
            open <= 1'b1;
            state <= last ? S_CAP : S_IDLE;
          end else begin
            dividend <= {dividend[QW-2:0], 1'b0};
            rem <= rem_next;
            if (quo[cfl_pkg::TimeW]) sat <= 1'b1;
            quo <= {quo[cfl_pkg::TimeW-1:0], q_bit};
            bit_cnt <= bit_cnt - 1'b1;
          end
        end
        S_CAP: begin
          // wait until the previous step has left the result register
          if (!out_valid || out_ready) begin
            if (previous_step != '0 && cap < running_minimum) time_step <= cap;
            else time_step <= running_minimum;
            state <= S_OUT;
          end
        end
        S_OUT: begin
          open <= 1'b0;
          running_minimum <= max_step;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// File: design/cfl_time_step_reduction.sv
// Top level of the CFL time step reduction block.
//  channel | signals                              | direction
//  zone    | in_valid/in_ready + zone fields      | in
//  step    | out_valid/out_ready + time_step      | out
//  config  | cfg_we, cfg_index, cfg_data          | in
// In the back end the restoring divider yields one quotient bit per cycle;
// zones with zero signal speed or negative width skip the divider.
// The last zone then passes through the growth cap and result register; the cap
// waits while an earlier step is still held unaccepted in the result register.
// Reset is synchronous; the front register and 4-entry queue let the input
// run ahead while the divider or the result register is stalled.
`timescale 1ns / 1ps
`default_nettype none
module cfl_time_step_reduction #(
  parameter int QueueDepth = cfl_pkg::QueueDepth
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [cfl_pkg::RadW-1:0]    inner_radius,
  input  wire logic [cfl_pkg::RadW-1:0]    outer_radius,
  input  wire logic signed [cfl_pkg::VelW-1:0] inner_velocity,
  input  wire logic signed [cfl_pkg::VelW-1:0] outer_velocity,
  input  wire logic [cfl_pkg::SndW-1:0]    sound_speed,
  input  wire logic                        last_zone,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [cfl_pkg::TimeW-1:0]        time_step,
  input  wire logic                        cfg_we,
  input  wire logic [2:0]                  cfg_index,
  input  wire logic [cfl_pkg::TimeW-1:0]   cfg_data
);
  logic [cfl_pkg::TimeW-1:0] max_step, previous_step;
  logic [cfl_pkg::CoefW-1:0] courant_factor, quad_viscosity, growth_limit;
  logic f_valid, f_ready, b_valid, b_ready;
  cfl_pkg::zone_t f_data, b_data;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      max_step <= cfl_pkg::MaxStepReset;
      courant_factor <= cfl_pkg::CourantReset;
      quad_viscosity <= cfl_pkg::ViscReset;
      growth_limit <= cfl_pkg::GrowthReset;
      previous_step <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        cfl_pkg::RegMaxStep: max_step <= cfg_data;
        cfl_pkg::RegCourant: courant_factor <= cfg_data[cfl_pkg::CoefW-1:0];
        cfl_pkg::RegVisc: quad_viscosity <= cfg_data[cfl_pkg::CoefW-1:0];
        cfl_pkg::RegGrowth: growth_limit <= cfg_data[cfl_pkg::CoefW-1:0];
        cfl_pkg::RegPrevStep: previous_step <= cfg_data;
        default: ;
      endcase
    end
  end

  cfl_front u_front (
    .clk, .rst, .in_valid, .in_ready, .inner_radius, .outer_radius,
    .inner_velocity, .outer_velocity, .sound_speed, .last_zone,
    .courant_factor, .quad_viscosity,
    .q_valid(f_valid), .q_ready(f_ready), .q_data(f_data)
  );

  cfl_queue #(.Depth(QueueDepth)) u_queue (
    .clk, .rst, .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_data),
    .rd_valid(b_valid), .rd_ready(b_ready), .rd_data(b_data)
  );

  cfl_back u_back (
    .clk, .rst, .q_valid(b_valid), .q_ready(b_ready), .q_data(b_data),
    .max_step, .growth_limit, .previous_step,
    .out_valid, .out_ready, .time_step
  );
endmodule
`default_nettype wire

// File: design/cfl_checker.sv
// Port-level checker for the CFL time step reduction block, with its bind.
`timescale 1ns / 1ps
`default_nettype none
module cfl_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [47:0] time_step
);
  // A waiting result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(time_step)) else $error("out hold");
  // A waiting zone stays offered
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid) else $error("in hold");
  // No result right out of reset
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid) else $error("reset valid");
  // No result on the first cycle after reset
  a_no_early: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !out_valid) else $error("early result");
endmodule
bind cfl_time_step_reduction cfl_checker u_checker (
  .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready, .time_step
);
`default_nettype wire
